@@ hdl/itoa_pkg.sv @@
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned DIGITS    = 10;
    localparam int unsigned BCD_W     = 4 * DIGITS;
    localparam int unsigned STEP_W    = $clog2(VALUE_W);
    localparam int unsigned DIGIT_CW  = $clog2(DIGITS + 1);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic trim;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic more_digits;
        logic negative;
        logic out_free;
    } status_t;

endpackage

@@ hdl/itoa_ctrl.sv @@
`timescale 1ns / 1ps

module itoa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  itoa_pkg::status_t status,
    output itoa_pkg::cmd_t    cmd
);
    import itoa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (status.conv_done) begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (!(status.top_zero && status.more_digits)) begin
                    state_next = status.negative ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (status.out_free && !status.more_digits) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CONVERT: begin
                cmd.step = 1'b1;
            end
            ST_TRIM: begin
                cmd.trim = status.top_zero && status.more_digits;
            end
            ST_SIGN: begin
                cmd.emit_sign = status.out_free;
            end
            ST_DIGITS: begin
                cmd.emit_digit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.step, cmd.trim, cmd.emit_sign, cmd.emit_digit}))
        else $error("More than one datapath command in a cycle.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONVERT && status.conv_done) |=> (state_reg == ST_TRIM))
        else $error("Conversion did not hand over to trimming.");

endmodule

@@ hdl/itoa_dp.sv @@
`timescale 1ns / 1ps

module itoa_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [itoa_pkg::VALUE_W-1:0] s_signed_value,
    input  itoa_pkg::cmd_t                     cmd,
    output itoa_pkg::status_t                  status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [7:0]                  m_char_code,
    output logic                               m_last_char
);
    import itoa_pkg::*;

    logic [VALUE_W-1:0]  bin_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic                neg_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [DIGIT_CW-1:0] dig_reg;
    logic [7:0]          char_reg;
    logic                last_reg;
    logic                m_valid_reg;

    logic [BCD_W-1:0]    bcd_adj;
    logic [VALUE_W-1:0]  mag;
    logic [3:0]          top_digit;

    assign mag       = s_signed_value[VALUE_W-1] ? (VALUE_W'(0) - s_signed_value)
                                                 : s_signed_value;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg <= mag;
            bcd_reg <= '0;
            neg_reg <= s_signed_value[VALUE_W-1];
            dig_reg <= DIGIT_CW'(DIGITS);
        end else if (cmd.step) begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end else if (cmd.trim || cmd.emit_digit) begin
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
            dig_reg <= dig_reg - DIGIT_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg <= '0;
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_sign || cmd.emit_digit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_sign) begin
            char_reg <= ASCII_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.emit_digit) begin
            char_reg <= ASCII_ZERO + {4'd0, top_digit};
            last_reg <= (dig_reg == DIGIT_CW'(1));
        end
    end

    assign status.conv_done   = (cnt_reg == STEP_W'(VALUE_W - 1));
    assign status.top_zero    = (top_digit == 4'd0);
    assign status.more_digits = (dig_reg > DIGIT_CW'(1));
    assign status.negative    = neg_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_char_code = char_reg;
    assign m_last_char = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_code == ASCII_MINUS ||
                     (m_char_code >= ASCII_ZERO && m_char_code <= ASCII_ZERO + 8'd9)))
        else $error("Output word is not a minus sign or a decimal digit.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_sign |-> neg_reg)
        else $error("Minus sign emitted for a non-negative value.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_sign || cmd.emit_digit) |-> (!m_valid_reg || m_ready))
        else $error("Output word overwritten before it was taken.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_char_code) && $stable(m_last_char)))
        else $error("Output word changed while it was waiting.");

endmodule

@@ hdl/signed_int_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps

// Converts one signed 32-bit word into its decimal text, sent one ASCII character per
// output word, most significant first, with a leading minus for negative values, no leading
// zeros, and m_last_char set on the final character. A word goes through a load, 32
// shift-and-add-3 steps of the binary-to-BCD converter, one trim step per leading zero dropped
// (10 minus the digit count), a step that picks the sign or first digit, and then one
// character per cycle while the output side keeps taking them; output stalls hold the
// characters back. The next word is accepted as soon as the final character has been
// placed in the output register.

module signed_int_to_decimal_ascii_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [itoa_pkg::VALUE_W-1:0] s_signed_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [7:0]                   m_char_code,
    output logic                                m_last_char
);
    import itoa_pkg::*;

    cmd_t    cmd;
    status_t status;

    itoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    itoa_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_signed_value (s_signed_value),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_char_code    (m_char_code),
        .m_last_char    (m_last_char)
    );

endmodule
